FILE: design/interpolated_map_lookup_with_history_top_macros.svh
// Assertion macros used by the checker file.
`ifndef INTERPOLATED_MAP_LOOKUP_WITH_HISTORY_TOP_MACROS_SVH
`define INTERPOLATED_MAP_LOOKUP_WITH_HISTORY_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define IMLH_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define IMLH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/imlh_pkg.sv
// Shared constants, codes and control types of the map lookup block.
package imlh_pkg;

   localparam int MAX_AXIS_POINTS_DEF = 16;
   localparam int NUM_MAPS_DEF        = 4;
   localparam int HISTORY_CELLS_DEF   = 14;
   localparam int TAP_LIMIT_DEF       = 12;

   localparam int FRAC_BITS   = 16;
   localparam int FETCH_CELLS = 4;

   localparam logic [30:0] CLAMP_HIGH_RESET   = 31'd5505024;
   localparam logic        COUNTER_MODE_RESET = 1'b1;
   localparam logic [30:0] DEAD_SCALE_RESET   = 31'd131072;
   localparam logic [31:0] DEAD_OFFSET_RESET  = 32'd131072;

   typedef enum logic [1:0] {
      CSR_CLAMP_HIGH   = 2'd0,
      CSR_COUNTER_MODE = 2'd1,
      CSR_DEAD_SCALE   = 2'd2,
      CSR_DEAD_OFFSET  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_X_POINT = 3'd0,
      KIND_Y_POINT = 3'd1,
      KIND_CELL    = 3'd2,
      KIND_X_COUNT = 3'd3,
      KIND_Y_COUNT = 3'd4,
      KIND_SCALE   = 3'd5,
      KIND_OFFSET  = 3'd6
   } load_kind_type;

   typedef struct packed {
      logic capture;
      logic load_wr;
      logic setup;
      logic scan_init;
      logic scan_run;
      logic axis;
      logic decide;
      logic div_run;
      logic row_base;
      logic fetch_run;
      logic blend_r0;
      logic blend_r1;
      logic col_blend;
      logic scale;
      logic finish;
      logic commit;
   } imlh_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic div_done;
      logic fetch_done;
   } imlh_status_type;

endpackage

FILE: design/imlh_ram.sv
// Generic simple dual-port RAM with registered read data.
module imlh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/imlh_ctrl.sv
// Sequencer that steps the datapath through load and lookup items.
module imlh_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      req_mode,
   input  imlh_pkg::imlh_status_type status,
   output imlh_pkg::imlh_cmd_type    cmd,
   output logic                      busy
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_SETUP, ST_SCAN_X, ST_DEC_X, ST_DIV_X, ST_INIT_Y,
      ST_SCAN_Y, ST_DEC_Y, ST_DIV_Y, ST_ROW_BASE, ST_FETCH, ST_BLEND0,
      ST_BLEND1, ST_COL_BLEND, ST_SCALE, ST_FINISH, ST_COMMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = req_mode ? ST_SETUP : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SETUP: begin
            cmd.setup     = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = ST_SCAN_X;
         end
         ST_SCAN_X: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DEC_X;
            end
         end
         ST_DEC_X: begin
            cmd.decide = 1'b1;
            state_in   = ST_DIV_X;
         end
         ST_DIV_X: begin
            cmd.div_run = 1'b1;
            if (status.div_done) begin
               state_in = ST_INIT_Y;
            end
         end
         ST_INIT_Y: begin
            cmd.scan_init = 1'b1;
            state_in      = ST_SCAN_Y;
         end
         ST_SCAN_Y: begin
            cmd.axis     = 1'b1;
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DEC_Y;
            end
         end
         ST_DEC_Y: begin
            cmd.axis   = 1'b1;
            cmd.decide = 1'b1;
            state_in   = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            cmd.axis    = 1'b1;
            cmd.div_run = 1'b1;
            if (status.div_done) begin
               state_in = ST_ROW_BASE;
            end
         end
         ST_ROW_BASE: begin
            cmd.row_base = 1'b1;
            state_in     = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch_run = 1'b1;
            if (status.fetch_done) begin
               state_in = ST_BLEND0;
            end
         end
         ST_BLEND0: begin
            cmd.blend_r0 = 1'b1;
            state_in     = ST_BLEND1;
         end
         ST_BLEND1: begin
            cmd.blend_r1 = 1'b1;
            state_in     = ST_COL_BLEND;
         end
         ST_COL_BLEND: begin
            cmd.col_blend = 1'b1;
            state_in      = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: design/imlh_dpath.sv
// Map stores, axis scan, fraction divider, blend arithmetic and history.
module imlh_dpath #(
   parameter int MAX_AXIS_POINTS = imlh_pkg::MAX_AXIS_POINTS_DEF,
   parameter int NUM_MAPS        = imlh_pkg::NUM_MAPS_DEF,
   parameter int HISTORY_CELLS   = imlh_pkg::HISTORY_CELLS_DEF,
   parameter int TAP_LIMIT       = imlh_pkg::TAP_LIMIT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  imlh_pkg::imlh_cmd_type    cmd,
   output imlh_pkg::imlh_status_type status,
   input  logic [1:0]                req_map_select,
   input  logic [2:0]                req_load_kind,
   input  logic [7:0]                req_load_index,
   input  logic [31:0]               req_load_value,
   input  logic signed [31:0]        req_x_in,
   input  logic signed [31:0]        req_y_in,
   input  logic [7:0]                req_sel_first,
   input  logic [7:0]                req_sel_second,
   input  logic [7:0]                req_sel_third,
   input  logic signed [31:0]        req_dead_path_in,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_write_data,
   output logic                      rsp_valid,
   output logic [30:0]               rsp_lookup_value,
   output logic [30:0]               rsp_delayed_value,
   output logic [3:0]                rsp_tap_index,
   output logic [1:0]                rsp_map_used
);

   localparam int CPM     = MAX_AXIS_POINTS * MAX_AXIS_POINTS;
   localparam int IW      = $clog2(MAX_AXIS_POINTS);
   localparam int NW      = $clog2(MAX_AXIS_POINTS + 1);
   localparam int MW      = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;
   localparam int BDEPTH  = NUM_MAPS * MAX_AXIS_POINTS;
   localparam int BAW     = $clog2(BDEPTH);
   localparam int GDEPTH  = NUM_MAPS * CPM;
   localparam int GAW     = $clog2(GDEPTH);
   localparam int OW      = $clog2(CPM) + 1;
   localparam int TW      = $clog2(HISTORY_CELLS);
   localparam int TAP_MAX = (TAP_LIMIT < HISTORY_CELLS - 1) ? TAP_LIMIT : HISTORY_CELLS - 1;
   localparam int FB      = imlh_pkg::FRAC_BITS;
   localparam int CW      = $clog2(FB);
   localparam int FCW     = $clog2(imlh_pkg::FETCH_CELLS + 1);

   function automatic logic [NW-1:0] eff_count(input logic [4:0] c);
      logic [NW-1:0] n;
      if (32'(c) > MAX_AXIS_POINTS) begin
         n = NW'(MAX_AXIS_POINTS);
      end else if (c == 5'd0) begin
         n = NW'(1);
      end else begin
         n = NW'(c);
      end
      return n;
   endfunction

   // configuration
   logic [30:0] clamp_ff, dscale_ff;
   logic        cmode_ff;
   logic [31:0] doff_ff;

   // latched item
   logic [1:0]         msel_ff;
   logic [2:0]         kind_ff;
   logic [7:0]         li_ff;
   logic [31:0]        lv_ff;
   logic signed [31:0] x_ff, y_ff, dp_ff;
   logic [MW-1:0]      map_ff, map_in;

   // small per-map stores
   logic [4:0]  xcnt_ff  [NUM_MAPS];
   logic [4:0]  ycnt_ff  [NUM_MAPS];
   logic [31:0] scale_ff [NUM_MAPS];
   logic [31:0] offs_ff  [NUM_MAPS];

   logic [NW-1:0]      nx_ff, ny_ff;
   logic [31:0]        mscale_ff, moff_ff;
   logic signed [63:0] dprod_ff;

   // scan
   logic [NW-1:0]      rd_idx_ff, rtag_ff, n_cur;
   logic               rvalid_ff, found_ff, issue, last_tag, hit;
   logic signed [31:0] prev_ff, a0_ff, last_ff, lo_ff, hi_ff, c_cur, bq;
   logic [IW-1:0]      fseg_ff, seg_in;
   logic [31:0]        xq, yq;
   logic [BAW-1:0]     b_rd_addr, b_wr_addr;
   logic               use_in;

   // divider
   logic              use_ff;
   logic [31:0]       rem_ff, den_ff;
   logic [FB-1:0]     quo_ff, quo_in;
   logic [CW-1:0]     dcnt_ff;
   logic [32:0]       div_sh;
   logic              div_ge;
   logic signed [32:0] num_d, den_d;
   logic [IW-1:0]     ix_ff, iy_ff;
   logic [FB-1:0]     tx_ff, ty_ff;

   // fetch
   logic [OW-1:0]  base0_ff, base1_ff, base0_in, foff;
   logic [FCW-1:0] fc_ff;
   logic           fvalid_ff, fissue;
   logic [1:0]     ftag_ff;
   logic [15:0]    cell_ff [imlh_pkg::FETCH_CELLS];
   logic [GAW-1:0] g_rd_addr, g_wr_addr;
   logic [15:0]    gq;

   // arithmetic
   logic [15:0]        v0, v1e, v2, v3e;
   logic signed [16:0] d0, d1;
   logic signed [33:0] p0, p1, r0_ff, r1_ff, r0_in, r1_in, r1e;
   logic signed [34:0] dr;
   logic signed [51:0] pc, acc;
   logic [31:0]        iv_ff;
   logic signed [64:0] sp_ff, sp_sh;
   logic signed [65:0] vsum;
   logic [30:0]        val_ff, val_in;
   logic signed [63:0] dsh;
   logic signed [64:0] dval;
   logic [64:0]        dpos, rnd;
   logic [TW-1:0]      tap_ff, tap_in;

   // history
   logic [30:0] hist_ff [HISTORY_CELLS];
   logic [30:0] hist_in [HISTORY_CELLS];
   logic [30:0] delayed;

   logic x_we, y_we, g_we, map_ok;

   imlh_ram #(.WIDTH(32), .DEPTH(BDEPTH)) u_xbp (
      .clock(clock), .wr_en(x_we), .wr_addr(b_wr_addr), .wr_data(lv_ff),
      .rd_addr(b_rd_addr), .rd_data(xq));

   imlh_ram #(.WIDTH(32), .DEPTH(BDEPTH)) u_ybp (
      .clock(clock), .wr_en(y_we), .wr_addr(b_wr_addr), .wr_data(lv_ff),
      .rd_addr(b_rd_addr), .rd_data(yq));

   imlh_ram #(.WIDTH(16), .DEPTH(GDEPTH)) u_grid (
      .clock(clock), .wr_en(g_we), .wr_addr(g_wr_addr), .wr_data(lv_ff[15:0]),
      .rd_addr(g_rd_addr), .rd_data(gq));

   // load path
   always_comb begin
      map_ok    = (32'(msel_ff) < NUM_MAPS);
      x_we      = cmd.load_wr && map_ok && (kind_ff == imlh_pkg::KIND_X_POINT)
                  && (32'(li_ff) < MAX_AXIS_POINTS);
      y_we      = cmd.load_wr && map_ok && (kind_ff == imlh_pkg::KIND_Y_POINT)
                  && (32'(li_ff) < MAX_AXIS_POINTS);
      g_we      = cmd.load_wr && map_ok && (kind_ff == imlh_pkg::KIND_CELL)
                  && (32'(li_ff) < CPM);
      b_wr_addr = BAW'(32'(msel_ff) * MAX_AXIS_POINTS + 32'(li_ff));
      g_wr_addr = GAW'(32'(msel_ff) * CPM + 32'(li_ff));
   end

   // map pick
   always_comb begin
      if (req_sel_first == 8'd1) begin
         map_in = MW'(0);
      end else if (req_sel_second == 8'd1) begin
         map_in = (NUM_MAPS > 1) ? MW'(1) : MW'(NUM_MAPS - 1);
      end else if (req_sel_third == 8'd1) begin
         map_in = (NUM_MAPS > 2) ? MW'(2) : MW'(NUM_MAPS - 1);
      end else begin
         map_in = (NUM_MAPS > 3) ? MW'(3) : MW'(NUM_MAPS - 1);
      end
   end

   // axis scan and decision, plus all status flags
   always_comb begin
      n_cur     = cmd.axis ? ny_ff : nx_ff;
      c_cur     = cmd.axis ? y_ff : x_ff;
      bq        = cmd.axis ? $signed(yq) : $signed(xq);
      issue     = cmd.scan_run && (rd_idx_ff < n_cur);
      b_rd_addr = BAW'(32'(map_ff) * MAX_AXIS_POINTS + 32'(rd_idx_ff));
      last_tag  = rvalid_ff && (rtag_ff == n_cur - NW'(1));
      hit       = rvalid_ff && (rtag_ff != '0) && !found_ff
                  && (prev_ff <= c_cur) && (c_cur < bq);
      status.scan_done  = cmd.scan_run && last_tag;
      status.fetch_done = cmd.fetch_run && fvalid_ff && (ftag_ff == 2'd3);

      if (!(c_cur < last_ff)) begin
         seg_in = IW'(n_cur - NW'(1));
         use_in = 1'b0;
      end else if (c_cur < a0_ff) begin
         seg_in = '0;
         use_in = 1'b0;
      end else if (found_ff) begin
         seg_in = fseg_ff;
         use_in = 1'b1;
      end else begin
         seg_in = IW'(n_cur - NW'(1));
         use_in = 1'b0;
      end
      num_d = 33'(c_cur) - 33'(lo_ff);
      den_d = 33'(hi_ff) - 33'(lo_ff);

      div_sh = {rem_ff, 1'b0};
      div_ge = (div_sh >= {1'b0, den_ff});
      quo_in = {quo_ff[FB-2:0], div_ge};
      status.div_done = cmd.div_run && (dcnt_ff == CW'(FB - 1));
   end

   // cell fetch
   always_comb begin
      base0_in  = OW'(iy_ff) * OW'(nx_ff);
      fissue    = cmd.fetch_run && (32'(fc_ff) < imlh_pkg::FETCH_CELLS);
      foff      = (fc_ff[1] ? base1_ff : base0_ff) + OW'(ix_ff) + OW'(fc_ff[0]);
      g_rd_addr = GAW'(32'(map_ff) * CPM + 32'(foff));
   end

   // blends; a zero fraction leaves the neighbor out
   always_comb begin
      v0    = cell_ff[0];
      v1e   = (tx_ff == '0) ? cell_ff[0] : cell_ff[1];
      v2    = cell_ff[2];
      v3e   = (tx_ff == '0) ? cell_ff[2] : cell_ff[3];
      d0    = $signed({1'b0, v1e}) - $signed({1'b0, v0});
      d1    = $signed({1'b0, v3e}) - $signed({1'b0, v2});
      p0    = $signed({1'b0, tx_ff}) * d0;
      p1    = $signed({1'b0, tx_ff}) * d1;
      r0_in = $signed({2'b00, v0, 16'h0000}) + p0;
      r1_in = $signed({2'b00, v2, 16'h0000}) + p1;
      r1e   = (ty_ff == '0) ? r0_ff : r1_ff;
      dr    = 35'(r1e) - 35'(r0_ff);
      pc    = $signed({1'b0, ty_ff}) * dr;
      acc   = 52'($signed({r0_ff, 16'h0000})) + pc;

      sp_sh = sp_ff >>> 24;
      vsum  = 66'(sp_sh) + 66'($signed(moff_ff));
      if (vsum <= 66'sd0) begin
         val_in = '0;
      end else if (vsum > $signed({35'd0, clamp_ff})) begin
         val_in = clamp_ff;
      end else begin
         val_in = vsum[30:0];
      end

      dsh  = dprod_ff >>> 19;
      dval = 65'(dsh) - 65'($signed(doff_ff));
      dpos = dval[64] ? '0 : dval;
      rnd  = (dpos + 65'd32768) >> 16;
      if (cmode_ff) begin
         tap_in = '0;
      end else if (rnd > 65'(TAP_MAX)) begin
         tap_in = TW'(TAP_MAX);
      end else begin
         tap_in = TW'(rnd);
      end
   end

   // history shift: new value into cells 0 and 1, the delayed (tap) value into the tail
   always_comb begin
      delayed = (tap_ff == '0) ? val_ff : hist_ff[tap_ff];
      hist_in[0] = val_ff;
      for (int k = 1; k < HISTORY_CELLS - 1; k++) begin
         hist_in[k] = (k == 1) ? val_ff : hist_ff[k-1];
      end
      hist_in[HISTORY_CELLS-1] = delayed;
   end

   // control and reset-cleared state
   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff  <= imlh_pkg::CLAMP_HIGH_RESET;
         cmode_ff  <= imlh_pkg::COUNTER_MODE_RESET;
         dscale_ff <= imlh_pkg::DEAD_SCALE_RESET;
         doff_ff   <= imlh_pkg::DEAD_OFFSET_RESET;
         rvalid_ff <= 1'b0;
         fvalid_ff <= 1'b0;
         rsp_valid <= 1'b0;
         for (int k = 0; k < HISTORY_CELLS; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            case (imlh_pkg::csr_index_type'(csr_index))
               imlh_pkg::CSR_CLAMP_HIGH:   clamp_ff  <= csr_write_data[30:0];
               imlh_pkg::CSR_COUNTER_MODE: cmode_ff  <= csr_write_data[0];
               imlh_pkg::CSR_DEAD_SCALE:   dscale_ff <= csr_write_data[30:0];
               imlh_pkg::CSR_DEAD_OFFSET:  doff_ff   <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.scan_init) begin
            rvalid_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            rvalid_ff <= issue;
         end
         if (cmd.row_base) begin
            fvalid_ff <= 1'b0;
         end else if (cmd.fetch_run) begin
            fvalid_ff <= fissue;
         end
         rsp_valid <= cmd.commit;
         if (cmd.commit) begin
            for (int k = 0; k < HISTORY_CELLS; k++) begin
               hist_ff[k] <= hist_in[k];
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         msel_ff <= req_map_select;
         kind_ff <= req_load_kind;
         li_ff   <= req_load_index;
         lv_ff   <= req_load_value;
         x_ff    <= req_x_in;
         y_ff    <= req_y_in;
         dp_ff   <= req_dead_path_in;
         map_ff  <= map_in;
      end
      if (cmd.load_wr && map_ok) begin
         case (imlh_pkg::load_kind_type'(kind_ff))
            imlh_pkg::KIND_X_COUNT: xcnt_ff[MW'(msel_ff)]  <= lv_ff[4:0];
            imlh_pkg::KIND_Y_COUNT: ycnt_ff[MW'(msel_ff)]  <= lv_ff[4:0];
            imlh_pkg::KIND_SCALE:   scale_ff[MW'(msel_ff)] <= lv_ff;
            imlh_pkg::KIND_OFFSET:  offs_ff[MW'(msel_ff)]  <= lv_ff;
            default: ;
         endcase
      end
      if (cmd.setup) begin
         nx_ff     <= eff_count(xcnt_ff[map_ff]);
         ny_ff     <= eff_count(ycnt_ff[map_ff]);
         mscale_ff <= scale_ff[map_ff];
         moff_ff   <= offs_ff[map_ff];
         dprod_ff  <= dp_ff * $signed({1'b0, dscale_ff});
      end
      if (cmd.scan_init) begin
         rd_idx_ff <= '0;
         found_ff  <= 1'b0;
      end else if (cmd.scan_run) begin
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + NW'(1);
         end
         rtag_ff <= rd_idx_ff;
         if (rvalid_ff) begin
            prev_ff <= bq;
            if (rtag_ff == '0) begin
               a0_ff <= bq;
            end
            if (last_tag) begin
               last_ff <= bq;
            end
            if (hit) begin
               found_ff <= 1'b1;
               fseg_ff  <= IW'(rtag_ff - NW'(1));
               lo_ff    <= prev_ff;
               hi_ff    <= bq;
            end
         end
      end
      if (cmd.decide) begin
         if (cmd.axis) begin
            iy_ff <= seg_in;
         end else begin
            ix_ff <= seg_in;
         end
         use_ff  <= use_in;
         rem_ff  <= num_d[31:0];
         den_ff  <= den_d[31:0];
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_run) begin
         rem_ff  <= div_ge ? 32'(div_sh - {1'b0, den_ff}) : div_sh[31:0];
         quo_ff  <= quo_in;
         dcnt_ff <= dcnt_ff + CW'(1);
         if (status.div_done) begin
            if (cmd.axis) begin
               ty_ff <= use_ff ? quo_in : '0;
            end else begin
               tx_ff <= use_ff ? quo_in : '0;
            end
         end
      end
      if (cmd.row_base) begin
         base0_ff <= base0_in;
         base1_ff <= base0_in + OW'(nx_ff);
         fc_ff    <= '0;
      end
      if (cmd.fetch_run) begin
         if (fissue) begin
            fc_ff <= fc_ff + FCW'(1);
         end
         ftag_ff <= fc_ff[1:0];
         if (fvalid_ff) begin
            cell_ff[ftag_ff] <= gq;
         end
      end
      if (cmd.blend_r0) begin
         r0_ff <= r0_in;
      end
      if (cmd.blend_r1) begin
         r1_ff <= r1_in;
      end
      if (cmd.col_blend) begin
         iv_ff  <= acc[47:16];
         tap_ff <= tap_in;
      end
      if (cmd.scale) begin
         sp_ff <= $signed({1'b0, iv_ff}) * $signed(mscale_ff);
      end
      if (cmd.finish) begin
         val_ff <= val_in;
      end
      if (cmd.commit) begin
         rsp_lookup_value  <= val_ff;
         rsp_delayed_value <= delayed;
         rsp_tap_index     <= 4'(tap_ff);
         rsp_map_used      <= 2'(map_ff);
      end
   end

endmodule

FILE: design/interpolated_map_lookup_with_history_top.sv
// Top level of the bilinear map lookup with result history.
//
// Usage:
//   Input channel: drive start with the req_* fields; the item transfers at a
//   rising edge where start is high and busy is low. req_mode 0 loads one
//   word into a calibration map, req_mode 1 runs one lookup.
//   A load holds busy for one cycle and gives no result.
//   A lookup runs the two axis scans (one breakpoint RAM read a cycle) and
//   two 16-step restoring divisions before the edge that writes the result;
//   the result shows on rsp_* with rsp_valid high for exactly
//   the next cycle, and busy drops in that same cycle.
//   The receiver cannot stall: rsp_valid is a one-cycle strobe, capture it.
//   Configuration: csr_write_enable, csr_index and csr_write_data write one
//   register per cycle; write only while busy is low (the block does not enforce it).
//   Reset (synchronous, active high) returns the sequencer to idle, restores
//   the register defaults and clears the history. Map contents are undefined
//   until loaded; there is no clearing pass.
module interpolated_map_lookup_with_history_top #(
   parameter int MAX_AXIS_POINTS = imlh_pkg::MAX_AXIS_POINTS_DEF,
   parameter int NUM_MAPS        = imlh_pkg::NUM_MAPS_DEF,
   parameter int HISTORY_CELLS   = imlh_pkg::HISTORY_CELLS_DEF,
   parameter int TAP_LIMIT       = imlh_pkg::TAP_LIMIT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [1:0]         req_map_select,
   input  logic [2:0]         req_load_kind,
   input  logic [7:0]         req_load_index,
   input  logic [31:0]        req_load_value,
   input  logic signed [31:0] req_x_in,
   input  logic signed [31:0] req_y_in,
   input  logic [7:0]         req_sel_first,
   input  logic [7:0]         req_sel_second,
   input  logic [7:0]         req_sel_third,
   input  logic signed [31:0] req_dead_path_in,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   output logic               rsp_valid,
   output logic [30:0]        rsp_lookup_value,
   output logic [30:0]        rsp_delayed_value,
   output logic [3:0]         rsp_tap_index,
   output logic [1:0]         rsp_map_used
);

   imlh_pkg::imlh_cmd_type    cmd;
   imlh_pkg::imlh_status_type status;

   // sequencer: one state per phase of a load or a lookup
   imlh_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // datapath: stores, scan, divider, blend, history
   imlh_dpath #(
      .MAX_AXIS_POINTS (MAX_AXIS_POINTS),
      .NUM_MAPS        (NUM_MAPS),
      .HISTORY_CELLS   (HISTORY_CELLS),
      .TAP_LIMIT       (TAP_LIMIT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_map_select    (req_map_select),
      .req_load_kind     (req_load_kind),
      .req_load_index    (req_load_index),
      .req_load_value    (req_load_value),
      .req_x_in          (req_x_in),
      .req_y_in          (req_y_in),
      .req_sel_first     (req_sel_first),
      .req_sel_second    (req_sel_second),
      .req_sel_third     (req_sel_third),
      .req_dead_path_in  (req_dead_path_in),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_lookup_value  (rsp_lookup_value),
      .rsp_delayed_value (rsp_delayed_value),
      .rsp_tap_index     (rsp_tap_index),
      .rsp_map_used      (rsp_map_used)
   );

endmodule

FILE: design/imlh_checker.sv
// Port-level checker for the map lookup block, with its bind.
`include "interpolated_map_lookup_with_history_top_macros.svh"

module imlh_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_mode,
   input logic rsp_valid
);

   `IMLH_ASSERT_SAME(a_result_when_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `IMLH_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "strobe too long")
   `IMLH_ASSERT_NEXT(a_load_no_result, clock, reset, start && !busy && !req_mode, busy && !rsp_valid, "load misbehaves")
   `IMLH_ASSERT_NEXT(a_step_busy, clock, reset, start && !busy && req_mode, busy && !rsp_valid, "lookup not busy")

endmodule

bind interpolated_map_lookup_with_history_top imlh_checker u_imlh_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_mode  (req_mode),
   .rsp_valid (rsp_valid)
);
